### design/spdc_pkg.sv
package spdc_pkg;

  // field widths
  localparam int COUNT_W  = 16;
  localparam int MAG_W    = 15;
  localparam int TARGET_W = 24;
  localparam int GAIN_W   = 18;
  localparam int SCALE_W  = 24;
  localparam int SPEED_W  = 24;
  localparam int DRIVE_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  // internal widths
  localparam int ERR_W   = 25;
  localparam int SUM_W   = 20;
  localparam int DIFF_W  = 26;
  localparam int PROD_W  = 39;   // count times scale, already shifted down by 8
  localparam int ADD_W   = 28;   // one serial step's addend
  localparam int HI_W    = 29;   // upper part of the shift-add accumulator
  localparam int STEP_W  = 5;

  // one step per gain bit; the speed product uses the same step count
  localparam int MAC_STEPS = GAIN_W;

  localparam logic [MAG_W-1:0]            MAG_MAX      = 15'h7FFF;
  localparam logic [SPEED_W-2:0]          SPEED_MAX    = 23'h7FFFFF;
  localparam logic signed [ERR_W-1:0]     DEADBAND_Q8  = 25'sd128;
  localparam logic signed [DIFF_W-1:0]    INT_LIMIT_Q8 = 26'sd256000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE  = 3'd4;

  // register reset values
  localparam logic [TARGET_W-1:0] TARGET_RST = 24'd0;
  localparam logic [GAIN_W-1:0]   GAIN_P_RST = 18'd16384;
  localparam logic [GAIN_W-1:0]   GAIN_I_RST = 18'd131;
  localparam logic [GAIN_W-1:0]   GAIN_D_RST = 18'd9830;
  localparam logic [SCALE_W-1:0]  SCALE_RST  = 24'd65536;

  typedef struct packed {
    logic clear;
    logic step;
  } mac_ctl_t;

  typedef struct packed {
    logic [SPEED_W-1:0]       speed;
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIFF_W-1:0] diff;
  } err_res_t;

endpackage

### design/spdc_serial_mac.sv
module spdc_serial_mac (
  input  logic                               clk,
  input  spdc_pkg::mac_ctl_t                 ctl,
  input  logic signed [spdc_pkg::ADD_W-1:0]  addend,
  output logic signed [spdc_pkg::HI_W-1:0]   acc_hi,
  output logic [spdc_pkg::GAIN_W-1:0]        acc_lo
);
  import spdc_pkg::*;

  logic signed [HI_W-1:0] hi_r, hi_nxt;
  logic [GAIN_W-1:0]      lo_r, lo_nxt;
  logic signed [HI_W-1:0] hi_sum;

  // add at the top, shift one bit down into the low word
  assign hi_sum = hi_r + {{(HI_W-ADD_W){addend[ADD_W-1]}}, addend};

  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (ctl.clear) begin
      hi_nxt = '0;
      lo_nxt = '0;
    end else if (ctl.step) begin
      hi_nxt = hi_sum >>> 1;
      lo_nxt = {hi_sum[0], lo_r[GAIN_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign acc_hi = hi_r;
  assign acc_lo = lo_r;

endmodule

### design/spdc_err_path.sv
module spdc_err_path (
  input  logic [spdc_pkg::PROD_W-1:0]        prod_q8,
  input  logic [spdc_pkg::TARGET_W-1:0]      target_speed,
  input  logic signed [spdc_pkg::SUM_W-1:0]  error_sum,
  input  logic signed [spdc_pkg::ERR_W-1:0]  prev_err,
  output spdc_pkg::err_res_t                 res
);
  import spdc_pkg::*;

  logic [SPEED_W-2:0]       speed_sat;
  logic signed [ERR_W-1:0]  err_raw;
  logic signed [ERR_W-1:0]  err_db;
  logic signed [DIFF_W-1:0] sum_raw;
  logic signed [DIFF_W-1:0] sum_clamp;

  assign speed_sat = (|prod_q8[PROD_W-1:SPEED_W-1]) ? SPEED_MAX : prod_q8[SPEED_W-2:0];

  assign err_raw = $signed({target_speed[TARGET_W-1], target_speed}) -
                   $signed({2'b00, speed_sat});

  // deadband of half an rpm
  assign err_db = ((err_raw < DEADBAND_Q8) && (err_raw > -DEADBAND_Q8)) ? '0 : err_raw;

  assign sum_raw = {{(DIFF_W-SUM_W){error_sum[SUM_W-1]}}, error_sum} +
                   {{(DIFF_W-ERR_W){err_db[ERR_W-1]}}, err_db};

  always_comb begin
    if (sum_raw >= INT_LIMIT_Q8) begin
      sum_clamp = INT_LIMIT_Q8;
    end else if (sum_raw < -INT_LIMIT_Q8) begin
      sum_clamp = -INT_LIMIT_Q8;
    end else begin
      sum_clamp = sum_raw;
    end
  end

  assign res.speed = {1'b0, speed_sat};
  assign res.err   = err_db;
  assign res.sum   = sum_clamp[SUM_W-1:0];
  assign res.diff  = {err_db[ERR_W-1], err_db} - {prev_err[ERR_W-1], prev_err};

endmodule

### design/speed_pid_deadband_clamp.sv
// channel   dir  handshake           payload
// in        in   in_valid/in_stall   in_pulse_count (16, signed)
// out       out  out_valid/out_stall out_drive_value (32, signed), out_measured_speed (24)
// cfg       in   cfg_wr_en           cfg_index (3), cfg_wdata (24)
//
// one beat runs accept, 18 shift-add steps for count times scale, error, deadband and
// integral clamp, 18 shift-add steps for the three gains, and the output register load;
// the step count is the gain width of the serial mac
// a waiting result holds in the output register while the next beat is accepted; a
// finished beat waits in ST_DONE only while the output register is full and stalled
// synchronous active-low reset restores the register defaults and clears integral,
// previous error and all handshake state
module speed_pid_deadband_clamp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [spdc_pkg::COUNT_W-1:0]    in_pulse_count,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [spdc_pkg::DRIVE_W-1:0]    out_drive_value,
  output logic signed [spdc_pkg::SPEED_W-1:0]    out_measured_speed,
  input  logic                                   cfg_wr_en,
  input  logic [spdc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [spdc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import spdc_pkg::*;

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SPEED = 3'd1;
  localparam logic [2:0] ST_ERR   = 3'd2;
  localparam logic [2:0] ST_PID   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAC_STEPS - 1);

  // configuration registers
  logic [TARGET_W-1:0] target_r;
  logic [GAIN_W-1:0]   gain_p_r, gain_i_r, gain_d_r;
  logic [SCALE_W-1:0]  scale_r;

  // sequencer
  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // controller state
  logic signed [SUM_W-1:0] error_sum_r;
  logic signed [ERR_W-1:0] prev_err_r;

  // per-beat operands and serial shift registers
  logic [MAG_W-1:0]         mag_sr_r;
  logic [GAIN_W-1:0]        gp_sr_r, gi_sr_r, gd_sr_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic [SPEED_W-1:0]       speed_r;

  // output register
  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] drive_r;
  logic [SPEED_W-1:0]        meas_r;

  logic                   in_acc;
  logic                   out_load;
  logic [MAG_W-1:0]       mag_in;
  mac_ctl_t               mac_ctl;
  logic signed [ADD_W-1:0] addend;
  logic signed [HI_W-1:0] mac_hi;
  logic [GAIN_W-1:0]      mac_lo;
  err_res_t               err_res;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // magnitude, most negative count pinned to full scale
  always_comb begin
    if (!in_pulse_count[COUNT_W-1]) begin
      mag_in = in_pulse_count[MAG_W-1:0];
    end else if (in_pulse_count[MAG_W-1:0] == '0) begin
      mag_in = MAG_MAX;
    end else begin
      mag_in = MAG_W'(-in_pulse_count);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SPEED;
          step_nxt  = '0;
        end
      end
      ST_SPEED: begin
        if (step_r == LAST_STEP) begin
          state_nxt = ST_ERR;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_ERR: begin
        state_nxt = ST_PID;
        step_nxt  = '0;
      end
      ST_PID: begin
        if (step_r == LAST_STEP) begin
          state_nxt = ST_DONE;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  // serial mac control and the addend of each step
  assign mac_ctl.clear = in_acc || (state_r == ST_ERR);
  assign mac_ctl.step  = (state_r == ST_SPEED) || (state_r == ST_PID);

  always_comb begin
    addend = '0;
    if (state_r == ST_SPEED) begin
      // one count bit per step selects the scale
      addend = mag_sr_r[0] ? $signed({{(ADD_W-SCALE_W){1'b0}}, scale_r}) : '0;
    end else if (state_r == ST_PID) begin
      // one bit of each gain per step selects its operand
      addend = (gp_sr_r[0] ? $signed({{(ADD_W-ERR_W){err_r[ERR_W-1]}}, err_r}) : '0) +
               (gi_sr_r[0] ? $signed({{(ADD_W-SUM_W){sum_r[SUM_W-1]}}, sum_r}) : '0) +
               (gd_sr_r[0] ? $signed({{(ADD_W-DIFF_W){diff_r[DIFF_W-1]}}, diff_r}) : '0);
    end
  end

  spdc_serial_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .addend (addend),
    .acc_hi (mac_hi),
    .acc_lo (mac_lo)
  );

  // product shifted down by 8 is the raw Q.8 speed
  spdc_err_path u_err (
    .prod_q8      ({mac_hi, mac_lo[GAIN_W-1:8]}),
    .target_speed (target_r),
    .error_sum    (error_sum_r),
    .prev_err     (prev_err_r),
    .res          (err_res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      error_sum_r <= '0;
      prev_err_r  <= '0;
      target_r    <= TARGET_RST;
      gain_p_r    <= GAIN_P_RST;
      gain_i_r    <= GAIN_I_RST;
      gain_d_r    <= GAIN_D_RST;
      scale_r     <= SCALE_RST;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_ERR) begin
        error_sum_r <= err_res.sum;
        prev_err_r  <= err_res.err;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TARGET_SPEED: target_r <= cfg_wdata[TARGET_W-1:0];
          REG_GAIN_P:       gain_p_r <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_I:       gain_i_r <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_D:       gain_d_r <= cfg_wdata[GAIN_W-1:0];
          REG_SPEED_SCALE:  scale_r  <= cfg_wdata[SCALE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mag_sr_r <= mag_in;
    end else if (state_r == ST_SPEED) begin
      mag_sr_r <= {1'b0, mag_sr_r[MAG_W-1:1]};
    end
    if (state_r == ST_ERR) begin
      err_r   <= err_res.err;
      sum_r   <= err_res.sum;
      diff_r  <= err_res.diff;
      speed_r <= err_res.speed;
      gp_sr_r <= gain_p_r;
      gi_sr_r <= gain_i_r;
      gd_sr_r <= gain_d_r;
    end else if (state_r == ST_PID) begin
      gp_sr_r <= {1'b0, gp_sr_r[GAIN_W-1:1]};
      gi_sr_r <= {1'b0, gi_sr_r[GAIN_W-1:1]};
      gd_sr_r <= {1'b0, gd_sr_r[GAIN_W-1:1]};
    end
    if (out_load) begin
      // floor shift by 16 of the full sum; it always fits in 31 bits
      drive_r <= {mac_hi[HI_W-1], mac_hi, mac_lo[GAIN_W-1:GAIN_W-2]};
      meas_r  <= speed_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_value    = drive_r;
  assign out_measured_speed = meas_r;

endmodule

### design/spdc_checker.sv
module spdc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [spdc_pkg::DRIVE_W-1:0] out_drive_value,
  input logic signed [spdc_pkg::SPEED_W-1:0] out_measured_speed
);
  import spdc_pkg::*;

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_drive_value) &&
                                  $stable(out_measured_speed)))
    else $error("stalled result changed");

  // one beat at a time in the serial datapath
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while busy");

  // measured speed is a magnitude
  a_speed_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_measured_speed[SPEED_W-1])
    else $error("negative measured speed");

  // drive never needs more than 31 bits
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive_value[DRIVE_W-1] == out_drive_value[DRIVE_W-2]))
    else $error("drive value out of range");

endmodule

bind speed_pid_deadband_clamp spdc_checker u_checker (.*);

### tb/pid_drive_checker.sv
// watches both channels and the register port, predicts every drive beat and
// compares it with what the block hands out
module pid_drive_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [spdc_pkg::COUNT_W-1:0]   in_pulse_count,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [spdc_pkg::DRIVE_W-1:0]   out_drive_value,
  input  logic signed [spdc_pkg::SPEED_W-1:0]   out_measured_speed,
  input  logic                                  cfg_wr_en,
  input  logic [spdc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spdc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output int                                    mismatches,
  output int                                    drives_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import spdc_pkg::*;

  localparam longint DRIVE_HI = (longint'(1) <<< (DRIVE_W - 1)) - 1;
  localparam longint DRIVE_LO = -(longint'(1) <<< (DRIVE_W - 1));

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [SPEED_W-1:0] speed;
  } pid_beat_t;

  pid_beat_t drive_due_q[$];

  // shadow registers
  logic signed [TARGET_W-1:0] set_speed;
  logic [GAIN_W-1:0]          kp, ki, kd;
  logic [SCALE_W-1:0]         rpm_per_count;

  // controller state
  longint err_integral;
  longint last_err;

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic pid_beat_t pid_drive_step(input logic signed [COUNT_W-1:0] count);
    longint mag, speed, err, sum, acc, drive;
    pid_beat_t r;
    mag = (count < 0) ? -longint'(count) : longint'(count);
    if (mag > longint'(MAG_MAX)) mag = longint'(MAG_MAX);
    speed = (mag * longint'(rpm_per_count)) >>> 8;
    if (speed > longint'(SPEED_MAX)) speed = longint'(SPEED_MAX);
    err = longint'(set_speed) - speed;
    if (err < longint'(DEADBAND_Q8) && err > -longint'(DEADBAND_Q8)) err = 0;
    sum = err_integral + err;
    if (sum >= longint'(INT_LIMIT_Q8)) sum = longint'(INT_LIMIT_Q8);
    else if (sum < -longint'(INT_LIMIT_Q8)) sum = -longint'(INT_LIMIT_Q8);
    acc = longint'(kp) * err + longint'(ki) * sum + longint'(kd) * (err - last_err);
    err_integral = sum;
    last_err = err;
    drive = acc >>> 16;
    if (drive > DRIVE_HI) drive = DRIVE_HI;
    else if (drive < DRIVE_LO) drive = DRIVE_LO;
    r.drive = drive[DRIVE_W-1:0];
    r.speed = speed[SPEED_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    pid_beat_t want;
    if (!rst_n) begin
      set_speed = TARGET_RST;
      kp = GAIN_P_RST;
      ki = GAIN_I_RST;
      kd = GAIN_D_RST;
      rpm_per_count = SCALE_RST;
      err_integral = 0;
      last_err = 0;
      drive_due_q.delete();
      drives_due <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TARGET_SPEED: set_speed = cfg_wdata[TARGET_W-1:0];
          REG_GAIN_P:       kp = cfg_wdata[GAIN_W-1:0];
          REG_GAIN_I:       ki = cfg_wdata[GAIN_W-1:0];
          REG_GAIN_D:       kd = cfg_wdata[GAIN_W-1:0];
          REG_SPEED_SCALE:  rpm_per_count = cfg_wdata[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) drive_due_q.push_back(pid_drive_step(in_pulse_count));
      if (out_valid && !out_stall) begin
        if (drive_due_q.size() == 0) begin
          report("drive beat with none due", longint'(out_drive_value), 0);
        end else begin
          want = drive_due_q.pop_front();
          if (out_drive_value !== want.drive)
            report("drive_value", longint'(out_drive_value), longint'(want.drive));
          if (out_measured_speed !== want.speed)
            report("measured_speed", longint'(out_measured_speed), longint'(want.speed));
        end
      end
      drives_due <= drive_due_q.size();
    end
  end

endmodule

### tb/tb_speed_pid_deadband_clamp.sv
// stimulus and verdict for the speed pid; all prediction lives in pid_drive_checker
module tb_speed_pid_deadband_clamp;
  timeunit 1ns;
  timeprecision 1ps;
  import spdc_pkg::*;

  localparam int RAND_PHASES     = 8;
  localparam int BEATS_PER_PHASE = 50;
  localparam int HOLD_CYCLES     = 400;   // long receiver hold-off, fills the block
  localparam int END_CYCLES      = 100;   // give the last beat room to come out
  localparam int CALM_PHASE      = 4;     // no idling on either side
  localparam int HOLD_PHASE      = 2;
  localparam int PAUSE_PHASE     = 6;     // sender drains mid-phase
  localparam int SPEED_TOP       = 8388607;
  localparam int SPEED_BOTTOM    = -8388608;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [COUNT_W-1:0]  in_pulse_count;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [DRIVE_W-1:0]  out_drive_value;
  logic signed [SPEED_W-1:0]  out_measured_speed;
  logic                       cfg_wr_en;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;

  int mismatches;
  int drives_due;
  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  bit rx_hold;

  speed_pid_deadband_clamp dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pulse_count     (in_pulse_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_value    (out_drive_value),
    .out_measured_speed (out_measured_speed),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  pid_drive_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pulse_count     (in_pulse_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_value    (out_drive_value),
    .out_measured_speed (out_measured_speed),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .drives_due         (drives_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // receiver: short random stall bursts, stalled about 11 percent of the time
  initial begin
    int burst;
    out_stall = 1'b0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (burst > 0) burst--;
      else if (!calm && $urandom_range(999) < 15) burst = $urandom_range(1, 15);
      out_stall <= rx_hold || (burst > 0);
    end
  end

  // one long hold-off, counted here while the sender keeps offering beats
  initial begin
    rx_hold = 1'b0;
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // offer one count and hold it until the block takes it; sometimes idle first
  task automatic send_beat(input logic signed [COUNT_W-1:0] count);
    int gap;
    if (!calm && $urandom_range(99) < 40) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pulse_count <= count;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every predicted drive has come out
  task automatic wait_all_out();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drives_due != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // all five registers; optionally junk on the unused indexes, which must be ignored
  task automatic load_config(input logic [CFG_DATA_W-1:0] target,
                             input logic [CFG_DATA_W-1:0] kp,
                             input logic [CFG_DATA_W-1:0] ki,
                             input logic [CFG_DATA_W-1:0] kd,
                             input logic [CFG_DATA_W-1:0] scale,
                             input bit stray);
    if (stray)
      for (int r = REG_SPEED_SCALE + 1; r < 2 ** CFG_IDX_W; r++)
        write_reg(CFG_IDX_W'(r), CFG_DATA_W'($urandom));
    write_reg(REG_TARGET_SPEED, target);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_SPEED_SCALE, scale);
    cfg_wr_en <= 1'b0;
  endtask

  // gain with random junk above bit 17; the block keeps only the low bits
  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    logic [CFG_DATA_W-1:0] g;
    g = CFG_DATA_W'($urandom);
    case ($urandom_range(3))
      0: g[GAIN_W-1:0] = GAIN_W'($urandom_range(20000));
      1: g[GAIN_W-1:0] = '1;
      default: ;
    endcase
    return g;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_scale();
    case ($urandom_range(3))
      0: return CFG_DATA_W'($urandom_range(256, 2048));
      1: return CFG_DATA_W'(SCALE_RST + $urandom_range(4096));
      2: return CFG_DATA_W'($urandom_range(256, 200000));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // mostly counts clustered around the operating point, then noise and extremes
  function automatic logic signed [COUNT_W-1:0] pick_count(input int center);
    int k;
    int v;
    k = $urandom_range(99);
    if (k < 70) begin
      v = center + int'($urandom_range(600)) - 300;
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      if ($urandom_range(1)) v = -v;
    end else if (k < 90) begin
      v = int'($urandom_range(65535)) - 32768;
    end else begin
      case ($urandom_range(5))
        0: v = 32767;
        1: v = -32768;
        2: v = -32767;
        3: v = 1;
        4: v = -1;
        default: v = 0;
      endcase
    end
    return v[COUNT_W-1:0];
  endfunction

  initial begin
    logic signed [COUNT_W-1:0] limit_counts[6];
    logic signed [COUNT_W-1:0] band_counts[6];
    logic [CFG_DATA_W-1:0]     g_all, target;
    logic [CFG_DATA_W-1:0]     scale;
    longint                    sp;
    int                        center;

    limit_counts = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, 16'sh8000, -16'sd32767};
    // with scale 256 the speed equals the count, so target 1000 puts the error
    // right on both edges of the deadband
    band_counts = '{16'sd1000, 16'sd873, 16'sd872, 16'sd1127, 16'sd1128, -16'sd873};

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pulse_count = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, count extremes including the most negative count
    foreach (limit_counts[i]) send_beat(limit_counts[i]);
    wait_all_out();

    // deadband edges, plus junk writes to unused indexes
    load_config(24'd1000, 24'd65536, 24'd131, 24'd9830, 24'd256, 1'b1);
    foreach (band_counts[i]) send_beat(band_counts[i]);
    wait_all_out();

    // top target, top gains, top scale: integral clamps high, speed saturates
    g_all = '1;
    load_config(24'h7FFFFF, g_all, g_all, g_all, 24'hFFFFFF, 1'b0);
    send_beat(16'sd0);
    send_beat(16'sd0);
    send_beat(16'sd32767);
    wait_all_out();

    // bottom target against saturated speed: largest negative error and swing
    load_config(24'h800000, g_all, g_all, g_all, 24'hFFFFFF, 1'b0);
    send_beat(16'sd32767);
    send_beat(16'sh8000);
    send_beat(16'sd0);
    wait_all_out();

    // integral walks onto its upper limit exactly, all gains zero at the end
    load_config(24'd128000, 24'd0, 24'd65536, 24'd0, 24'd256, 1'b0);
    send_beat(16'sd0);
    send_beat(16'sd0);
    send_beat(16'sd0);
    wait_all_out();
    load_config(24'h800000, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0);
    send_beat(16'sh8000);
    wait_all_out();

    // random phases, each with its own settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      center = $urandom_range(32767);
      if (ph == 0) begin
        g_all = CFG_DATA_W'($urandom);
        g_all[GAIN_W-1:0] = '1;
        load_config(24'h7FFFFF, g_all, g_all, g_all, 24'hFFFFFF, 1'b1);
      end else if (ph == 1) begin
        load_config(24'h800000, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0);
      end else begin
        scale = pick_scale();
        if (scale > 24'd4096) center = $urandom_range(2000);
        if ($urandom_range(99) < 70) begin
          // set point near the speed of the typical count so the loop settles
          sp = (longint'(center) * longint'(scale)) >>> 8;
          sp = sp + longint'($urandom_range(6000)) - 3000;
          if (sp > SPEED_TOP) sp = SPEED_TOP;
          if (sp < SPEED_BOTTOM) sp = SPEED_BOTTOM;
          target = sp[CFG_DATA_W-1:0];
        end else begin
          target = CFG_DATA_W'($urandom);
        end
        load_config(target, pick_gain(), pick_gain(), pick_gain(), scale, ph == 3);
      end
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      calm = (ph == CALM_PHASE);
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        send_beat(pick_count(center));
        if (ph == PAUSE_PHASE && k == BEATS_PER_PHASE / 2) wait_all_out();
      end
      wait_all_out();
    end
    calm = 1'b0;

    // anything late or extra shows up in the checker during this wait
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
design/spdc_pkg.sv
design/spdc_serial_mac.sv
design/spdc_err_path.sv
design/speed_pid_deadband_clamp.sv
design/spdc_checker.sv
tb/pid_drive_checker.sv
tb/tb_speed_pid_deadband_clamp.sv
